>>> rtl/md5sh_pkg.sv
package md5sh_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // Sources of the byte written into the block buffer.
  localparam logic [1:0] WR_BYTE = 2'd0;
  localparam logic [1:0] WR_MARK = 2'd1;
  localparam logic [1:0] WR_PAD  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       final_item;
  } msg_t;

  typedef struct packed {
    logic [63:0] digest_part;
    logic        part_index;
    logic        last_part;
  } dig_t;

  typedef struct packed {
    logic       wr_en;
    logic [1:0] wr_kind;
    logic [5:0] wr_addr;
    logic       len_phase;
    logic       cnt_inc;
    logic       load_work;
    logic       pre_first;
    logic       round_en;
    logic       chain_add;
    logic       finish;
    logic [5:0] rnd;
    logic [5:0] rd_idx;
    logic [5:0] k_idx;
    logic       out_part;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] cnt_low;
  } dp_stat_t;

  // Message word used by a round.
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] n;
    n = i[3:0];
    unique case (i[5:4])
      2'd0: msg_index = n;
      2'd1: msg_index = {n[1:0], 2'b00} + n + 4'd1;
      2'd2: msg_index = {n[2:0], 1'b0} + n + 4'd5;
      2'd3: msg_index = {n[0], 3'b000} - n;
    endcase
  endfunction

  function automatic logic [4:0] shift_amt(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'h0: s = 5'd7;
      4'h1: s = 5'd12;
      4'h2: s = 5'd17;
      4'h3: s = 5'd22;
      4'h4: s = 5'd5;
      4'h5: s = 5'd9;
      4'h6: s = 5'd14;
      4'h7: s = 5'd20;
      4'h8: s = 5'd4;
      4'h9: s = 5'd11;
      4'ha: s = 5'd16;
      4'hb: s = 5'd23;
      4'hc: s = 5'd6;
      4'hd: s = 5'd10;
      4'he: s = 5'd15;
      4'hf: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0:  k = 32'hd76aa478;
      6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;
      6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;
      6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;
      6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;
      6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;
      6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;
      6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;
      6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;
      6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;
      6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;
      6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;
      6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;
      6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;
      6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;
      6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;
      6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;
      6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;
      6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;
      6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;
      6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;
      6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;
      6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;
      6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;
      6'd63: k = 32'heb86d391;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/md5_stream_hasher_top.sv
// One message byte per cycle; a byte that completes a 64-byte block stalls
// input through the buffer prefetch, 64 rounds and the chain add. A final request
// then writes the padding marker and zero padding, one more block of it when the
// length spills into a second block, compresses each block and loads the digest holding
// register once its previous digest has drained; both digest requests follow from it.
// Synchronous active-high reset restores the initial chaining words and a zero byte count.
module md5_stream_hasher_top import md5sh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic msg_valid,
  output logic msg_stall,
  input  msg_t msg,
  output logic dig_valid,
  input  logic dig_stall,
  output dig_t dig
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [63:0] dig_word;

  md5sh_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .byte_present (msg.byte_present),
    .final_item   (msg.final_item),
    .dig_valid    (dig_valid),
    .dig_stall    (dig_stall),
    .cmd          (cmd),
    .stat         (stat)
  );

  md5sh_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .data_byte (msg.data_byte),
    .cmd       (cmd),
    .stat      (stat),
    .dig_word  (dig_word)
  );

  assign dig.digest_part = dig_word;
  assign dig.part_index  = cmd.out_part;
  assign dig.last_part   = cmd.out_part;

  a_final_stalls: assert property (@(posedge clk) disable iff (rst)
    msg_valid && !msg_stall && msg.final_item |=> msg_stall)
    else $error("input not stalled after a final request");

  a_second_part: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_stall && !dig.last_part |=> dig_valid && dig.part_index)
    else $error("second digest part does not follow the first");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_stall && dig.last_part |=> !dig_valid)
    else $error("digest request repeated after the last part");

endmodule

>>> rtl/md5sh_ctrl.sv
module md5sh_ctrl import md5sh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     msg_valid,
  output logic     msg_stall,
  input  logic     byte_present,
  input  logic     final_item,
  output logic     dig_valid,
  input  logic     dig_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PRE0  = 3'd1;
  localparam logic [2:0] ST_PRE1  = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_MARK  = 3'd5;
  localparam logic [2:0] ST_PAD   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0] state;
  logic [5:0] rnd;
  logic [5:0] ptr;
  logic       pend;
  logic       padding;
  logic       len_phase;
  logic       out_part;
  logic       msg_take;
  logic       dig_take;
  logic       load_out;

  assign msg_stall = (state != ST_IDLE);
  assign msg_take  = msg_valid && !msg_stall;
  assign dig_take  = dig_valid && !dig_stall;
  assign load_out  = (state == ST_DONE) && !dig_valid;

  always_comb begin
    cmd = '0;
    cmd.rnd       = rnd;
    cmd.len_phase = len_phase;
    cmd.out_part  = out_part;
    unique case (state)
      ST_IDLE: begin
        cmd.wr_en   = msg_take && byte_present;
        cmd.wr_kind = WR_BYTE;
        cmd.wr_addr = stat.cnt_low;
        cmd.cnt_inc = msg_take && byte_present;
      end
      ST_PRE0: begin
        cmd.load_work = 1'b1;
      end
      ST_PRE1: begin
        cmd.pre_first = 1'b1;
        cmd.rd_idx    = 6'd1;
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        cmd.rd_idx   = rnd + 6'd2;
        cmd.k_idx    = rnd + 6'd1;
      end
      ST_FIN: begin
        cmd.chain_add = 1'b1;
      end
      ST_MARK: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_kind = WR_MARK;
        cmd.wr_addr = stat.cnt_low;
      end
      ST_PAD: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_kind = WR_PAD;
        cmd.wr_addr = ptr;
      end
      ST_DONE: begin
        cmd.finish = load_out;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rnd       <= '0;
      ptr       <= '0;
      pend      <= 1'b0;
      padding   <= 1'b0;
      len_phase <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (msg_take) begin
            if (byte_present && stat.cnt_low == 6'd63) begin
              state <= ST_PRE0;
              pend  <= final_item;
            end else if (final_item) begin
              state <= ST_MARK;
            end
          end
        end
        ST_PRE0: begin
          rnd   <= '0;
          state <= ST_PRE1;
        end
        ST_PRE1: begin
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (pend) begin
            pend  <= 1'b0;
            state <= ST_MARK;
          end else if (padding) begin
            if (len_phase) begin
              state <= ST_DONE;
            end else begin
              // The marker spilled past the length field: the length goes
              // into a fresh block of zeros.
              len_phase <= 1'b1;
              ptr       <= '0;
              state     <= ST_PAD;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_MARK: begin
          padding   <= 1'b1;
          len_phase <= (stat.cnt_low < 6'd56);
          ptr       <= stat.cnt_low + 6'd1;
          state     <= (stat.cnt_low == 6'd63) ? ST_PRE0 : ST_PAD;
        end
        ST_PAD: begin
          ptr <= ptr + 6'd1;
          if (ptr == 6'd63) begin
            state <= ST_PRE0;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            padding   <= 1'b0;
            len_phase <= 1'b0;
            state     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // The digest leaves as two requests from a holding register, so the
  // next message can start while they drain.
  always_ff @(posedge clk) begin
    if (rst) begin
      dig_valid <= 1'b0;
      out_part  <= 1'b0;
    end else if (load_out) begin
      dig_valid <= 1'b1;
      out_part  <= 1'b0;
    end else if (dig_take) begin
      if (out_part) begin
        dig_valid <= 1'b0;
      end else begin
        out_part <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/md5sh_dp.sv
module md5sh_dp import md5sh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic [63:0] dig_word
);

  logic [31:0] blk_mem [16];
  logic [31:0] mem_q;
  logic [31:0] chain [4];
  logic [31:0] a, b, c, d;
  logic [31:0] pre;
  logic [60:0] cnt;
  logic [63:0] dig_lo, dig_hi;
  logic [63:0] len_bits;
  logic [7:0]  wr_byte;
  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot_ext;
  logic [31:0] pre_base;

  assign stat.cnt_low = cnt[5:0];
  assign len_bits     = {cnt, 3'b000};
  assign dig_word     = cmd.out_part ? dig_hi : dig_lo;

  always_comb begin
    unique case (cmd.wr_kind)
      WR_BYTE: wr_byte = data_byte;
      WR_MARK: wr_byte = PAD_MARK;
      WR_PAD:  wr_byte = (cmd.len_phase && cmd.wr_addr[5:3] == 3'b111) ?
                         len_bits[{cmd.wr_addr[2:0], 3'b000} +: 8] : 8'h00;
      default: wr_byte = 8'h00;
    endcase
  end

  // Block buffer: one byte lane written per cycle, one word read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      blk_mem[cmd.wr_addr[5:2]][{cmd.wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
    end
    mem_q <= blk_mem[msg_index(cmd.rd_idx)];
  end

  always_comb begin
    unique case (cmd.rnd[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (d & b) | (~d & c);
      2'd2: f = b ^ c ^ d;
      2'd3: f = c ^ (b | ~d);
    endcase
    sum     = pre + f;
    rot_ext = {sum, sum} << shift_amt(cmd.rnd);
    // Next round's a is today's d, so its constant and message word are
    // summed into the pre register while the current round runs.
    pre_base = cmd.pre_first ? a : d;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
    end else if (cmd.round_en) begin
      a <= d;
      b <= b + rot_ext[63:32];
      c <= b;
      d <= c;
    end
    if (cmd.pre_first || cmd.round_en) begin
      pre <= pre_base + round_const(cmd.k_idx) + mem_q;
    end
    if (cmd.finish) begin
      dig_lo <= {chain[1], chain[0]};
      dig_hi <= {chain[3], chain[2]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      chain[0] <= IV_A;
      chain[1] <= IV_B;
      chain[2] <= IV_C;
      chain[3] <= IV_D;
      cnt      <= '0;
    end else begin
      if (cmd.chain_add) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
      end
      if (cmd.cnt_inc) begin
        cnt <= cnt + 61'd1;
      end
    end
  end

endmodule

>>> sim/md5_stream_hasher_top_tb.sv
`timescale 1ns / 1ps

module md5_stream_hasher_top_tb import md5sh_pkg::*;;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic msg_valid = 1'b0;
  logic msg_stall;
  msg_t msg_req = '0;
  logic dig_valid;
  logic dig_stall = 1'b0;
  dig_t dig;

  bit quiet = 1'b0;
  int sent_items = 0;
  int messages = 0;
  int idle_cycles = 0;
  int stall_run = 0;
  int free_run = 0;
  int boundary_len [12] = '{54, 55, 56, 57, 62, 63, 64, 65, 119, 120, 127, 128};

  // Software MD5 that tracks the block and queues the two digest words per message.
  class md5_digest_board;
    logic [31:0] chain [4];
    logic [7:0]  blk [64];
    logic [60:0] byte_cnt;
    logic [31:0] k_tab [64];
    int unsigned rot_tab [16];
    dig_t digest_q [$];
    int errors;
    int checked;

    function new();
      k_tab = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
      rot_tab = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      errors = 0;
      checked = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = IV_A;
      chain[1] = IV_B;
      chain[2] = IV_C;
      chain[3] = IV_D;
      byte_cnt = '0;
    endfunction

    function void compress();
      logic [31:0] a, b, c, d, f, t, w;
      int g;
      int s;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int i = 0; i < 64; i++) begin
        if (i < 16) begin
          f = (b & c) | (~b & d);
          g = i;
        end else if (i < 32) begin
          f = (d & b) | (~d & c);
          g = (5 * i + 1) % 16;
        end else if (i < 48) begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end else begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
        w = {blk[4*g+3], blk[4*g+2], blk[4*g+1], blk[4*g]};
        s = rot_tab[(i / 16) * 4 + (i % 4)];
        t = a + f + k_tab[i] + w;
        t = (t << s) | (t >> (32 - s));
        a = d;
        d = c;
        c = b;
        b = b + t;
      end
      chain[0] = chain[0] + a;
      chain[1] = chain[1] + b;
      chain[2] = chain[2] + c;
      chain[3] = chain[3] + d;
    endfunction

    function void note_request(msg_t m);
      int pos;
      logic [63:0] bit_len;
      dig_t part;
      if (m.byte_present) begin
        blk[byte_cnt[5:0]] = m.data_byte;
        byte_cnt = byte_cnt + 61'd1;
        if (byte_cnt[5:0] == 6'd0)
          compress();
      end
      if (!m.final_item)
        return;
      pos = int'(byte_cnt[5:0]);
      blk[pos] = PAD_MARK;
      pos++;
      // No room left for the length field, so the padding spills into one more block.
      if (pos > 56) begin
        while (pos < 64) begin
          blk[pos] = 8'h00;
          pos++;
        end
        compress();
        pos = 0;
      end
      while (pos < 56) begin
        blk[pos] = 8'h00;
        pos++;
      end
      bit_len = {byte_cnt, 3'b000};
      for (int i = 0; i < 8; i++)
        blk[56+i] = bit_len[8*i +: 8];
      compress();
      part.digest_part = {chain[1], chain[0]};
      part.part_index = 1'b0;
      part.last_part = 1'b0;
      digest_q.push_back(part);
      part.digest_part = {chain[3], chain[2]};
      part.part_index = 1'b1;
      part.last_part = 1'b1;
      digest_q.push_back(part);
      restart();
    endfunction

    function void check_result(dig_t got);
      dig_t want;
      if (digest_q.size() == 0) begin
        errors++;
        $display("%0t: digest word with nothing pending: expected none, got %h idx %0d last %0d",
                 $time, got.digest_part, got.part_index, got.last_part);
        return;
      end
      want = digest_q.pop_front();
      checked++;
      if (got.digest_part !== want.digest_part) begin
        errors++;
        $display("%0t: digest_part expected %h, got %h", $time, want.digest_part,
                 got.digest_part);
      end
      if (got.part_index !== want.part_index) begin
        errors++;
        $display("%0t: part_index expected %0d, got %0d", $time, want.part_index,
                 got.part_index);
      end
      if (got.last_part !== want.last_part) begin
        errors++;
        $display("%0t: last_part expected %0d, got %0d", $time, want.last_part,
                 got.last_part);
      end
    endfunction

    function int pending();
      return digest_q.size();
    endfunction
  endclass

  md5_digest_board board;

  md5_stream_hasher_top dut (
    .clk(clk),
    .rst(rst),
    .msg_valid(msg_valid),
    .msg_stall(msg_stall),
    .msg(msg_req),
    .dig_valid(dig_valid),
    .dig_stall(dig_stall),
    .dig(dig)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Digest side: check what is taken at this edge, then pick the stall for the next one.
  always @(posedge clk) begin
    if (rst) begin
      dig_stall <= 1'b0;
    end else begin
      if (dig_valid && !dig_stall)
        board.check_result(dig);
      if (quiet) begin
        dig_stall <= 1'b0;
      end else if (free_run > 0) begin
        free_run <= free_run - 1;
        dig_stall <= 1'b0;
      end else if (stall_run > 0) begin
        stall_run <= stall_run - 1;
        dig_stall <= 1'b1;
      end else begin
        free_run <= $urandom_range(0, 12);
        stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
                     $urandom_range(0, 3);
        dig_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (msg_valid && !msg_stall) || (dig_valid && !dig_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("md5_stream_hasher_top_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (quiet || sel < 70)
      return 0;
    else if (sel < 95)
      return $urandom_range(1, 3);
    else
      return $urandom_range(10, 40);
  endfunction

  task automatic send_request(input msg_t m);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg_req <= m;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
    board.note_request(m);
    if (m.byte_present || m.final_item)
      sent_items++;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit fin);
    msg_t m;
    m.data_byte = b;
    m.byte_present = 1'b1;
    m.final_item = fin;
    send_request(m);
  endtask

  task automatic send_empty(input bit fin);
    msg_t m;
    m.data_byte = 8'($urandom_range(0, 255));
    m.byte_present = 1'b0;
    m.final_item = fin;
    send_request(m);
  endtask

  // Holds the message side idle until every digest word has come back.
  task automatic wait_drained();
    msg_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic send_message(input int len, input bit empty_tail, input int noise_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_empty(1'b0);
      send_byte(8'($urandom_range(0, 255)), (i == len - 1) && !empty_tail);
    end
    if (len == 0 || empty_tail)
      send_empty(1'b1);
    messages++;
  endtask

  initial begin
    int sel;
    int len;
    board = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Empty message, then empty non-final requests ahead of another empty message.
    send_empty(1'b1);
    send_empty(1'b0);
    send_empty(1'b0);
    send_empty(1'b1);
    // Single bytes at both extremes, one closed by an empty final request.
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_empty(1'b1);
    // "abc" with an ignored request in the middle.
    send_byte(8'h61, 1'b0);
    send_empty(1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b1);
    messages += 6;
    wait_drained();

    // Mostly short messages; some land on the padding boundaries around 56, 64, 120 and 128 bytes.
    while (sent_items < 550) begin
      quiet = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 70)
        len = $urandom_range(0, 12);
      else if (sel < 88)
        len = boundary_len[$urandom_range(0, 11)];
      else
        len = $urandom_range(13, 140);
      send_message(len, 1'($urandom_range(0, 1)), quiet ? 0 : $urandom_range(0, 15));
      if ($urandom_range(0, 5) == 0)
        wait_drained();
    end

    wait_drained();
    quiet = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending() != 0) begin
      board.errors++;
      $display("%0t: digest words still pending: expected 0, got %0d", $time,
               board.pending());
    end

    $display("Hashed %0d messages from %0d byte and final requests, including empty ones",
             messages, sent_items);
    $display("and block-boundary lengths; %0d digest words compared, %0d mismatches.",
             board.checked, board.errors);
    if (board.errors == 0)
      $display("md5_stream_hasher_top_tb: clean");
    else
      $display("md5_stream_hasher_top_tb: errors");
    $finish;
  end

endmodule

>>> md5_stream_hasher_top.f
rtl/md5sh_pkg.sv
rtl/md5sh_ctrl.sv
rtl/md5sh_dp.sv
rtl/md5_stream_hasher_top.sv
sim/md5_stream_hasher_top_tb.sv
